/* sv/vrd_pkg.sv */
// shared types, field widths and codes of the voxel run-length decoder
package vrd_pkg;

   localparam int LEN_W      = 16;
   localparam int VAL_W      = 16;
   localparam int RIDX_W     = 15;
   localparam int STATUS_W   = 2;
   localparam int FILL_W     = 16;
   localparam int POS_W      = 7;
   localparam int STRIDE_W   = 11;
   localparam int STEP_W     = 2;
   localparam int LAYER_W    = 6;
   localparam int PROD_W     = POS_W + STRIDE_W + 1;
   localparam int IDX_W      = 21;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 11;

   localparam logic [STATUS_W-1:0] STAT_RUN_TAKEN  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_CHUNK_DONE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_CORRUPT    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_READ_DATA  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_START  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_STRIDE = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_END    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_STEP   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_START   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_STRIDE  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_END     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_STEP    = 4'd7;

   typedef struct packed {
      logic signed [POS_W-1:0]  middle_start;
      logic [STRIDE_W-1:0]      middle_stride;
      logic signed [POS_W-1:0]  middle_end;
      logic signed [STEP_W-1:0] middle_step;
      logic signed [POS_W-1:0]  inner_start;
      logic [STRIDE_W-1:0]      inner_stride;
      logic signed [POS_W-1:0]  inner_end;
      logic signed [STEP_W-1:0] inner_step;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      middle_start:  7'sd0,
      middle_stride: 11'd32,
      middle_end:    7'sd32,
      middle_step:   2'sd1,
      inner_start:   7'sd0,
      inner_stride:  11'd1,
      inner_end:     7'sd32,
      inner_step:    2'sd1
   };

   typedef struct packed {
      logic restart;
      logic advance;
   } walk_ctl_type;

endpackage

/* sv/vrd_if.sv */
// item channels and register write channel of the voxel run-length decoder
interface vrd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [vrd_pkg::LEN_W-1:0]  run_length;
   logic [vrd_pkg::VAL_W-1:0]  run_value;
   logic [vrd_pkg::RIDX_W-1:0] read_index;

   modport source (output valid, mode, run_length, run_value, read_index, input ready);
   modport sink   (input valid, mode, run_length, run_value, read_index, output ready);
endinterface

interface vrd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vrd_pkg::STATUS_W-1:0] status;
   logic [vrd_pkg::VAL_W-1:0]    read_value;
   logic [vrd_pkg::FILL_W-1:0]   filled_count;

   modport source (output valid, status, read_value, filled_count, input ready);
   modport sink   (input valid, status, read_value, filled_count, output ready);
endinterface

interface vrd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [vrd_pkg::CSR_IDX_W-1:0]  index;
   logic [vrd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/vrd_walk.sv */
// traversal position registers and store index computation
module vrd_walk #(
   parameter int EDGE_LENGTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  vrd_pkg::cfg_type                   cfg,
   input  vrd_pkg::walk_ctl_type              ctl,
   output logic signed [vrd_pkg::IDX_W-1:0]   index
);
   import vrd_pkg::*;

   localparam int LAYER_SIZE = EDGE_LENGTH * EDGE_LENGTH;

   logic [LAYER_W-1:0]       layer_ff, layer_in;
   logic signed [POS_W-1:0]  middle_ff, middle_in;
   logic signed [POS_W-1:0]  inner_ff, inner_in;
   logic signed [POS_W-1:0]  inner_inc, middle_inc;
   logic signed [PROD_W-1:0] prod_mid, prod_inn;
   logic [IDX_W-1:0]         layer_term;

   assign inner_inc  = inner_ff + POS_W'(cfg.inner_step);
   assign middle_inc = middle_ff + POS_W'(cfg.middle_step);

   assign prod_mid   = middle_ff * $signed({1'b0, cfg.middle_stride});
   assign prod_inn   = inner_ff * $signed({1'b0, cfg.inner_stride});
   assign layer_term = IDX_W'(layer_ff) * IDX_W'(LAYER_SIZE);
   assign index      = $signed(layer_term) + IDX_W'(prod_mid) + IDX_W'(prod_inn);

   always_comb begin
      layer_in  = layer_ff;
      middle_in = middle_ff;
      inner_in  = inner_ff;
      if (ctl.restart) begin
         layer_in  = '0;
         middle_in = cfg.middle_start;
         inner_in  = cfg.inner_start;
      end else if (ctl.advance) begin
         inner_in = inner_inc;
         if (inner_inc == cfg.inner_end) begin
            inner_in  = cfg.inner_start;
            middle_in = middle_inc;
            if (middle_inc == cfg.middle_end) begin
               middle_in = cfg.middle_start;
               layer_in  = layer_ff + LAYER_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff  <= '0;
         middle_ff <= CFG_RST.middle_start;
         inner_ff  <= CFG_RST.inner_start;
      end else begin
         layer_ff  <= layer_in;
         middle_ff <= middle_in;
         inner_ff  <= inner_in;
      end
   end

endmodule

/* sv/voxel_rle_decoder_core.sv */
// top level of the voxel run-length decoder: sequencer, voxel store and register file
//
// A run item of n voxels writes one voxel per cycle through the single write port of the
// voxel store and ends early when it stops on a full store or a corrupt index; a read
// item passes through the registered read of the store. A write to a known register holds
// off the next item while the traversal restarts. The store is not cleared at reset: read
// only voxels that were written. Results wait in an output register, so the next item can
// be accepted while the previous result has not been taken.
module voxel_rle_decoder_core #(
   parameter int EDGE_LENGTH = 32,
   parameter int VALUE_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   vrd_req_if.sink   req_bus,
   vrd_rsp_if.source rsp_bus,
   vrd_csr_if.sink   csr_bus
);
   import vrd_pkg::*;

   localparam int STORE_SIZE = EDGE_LENGTH * EDGE_LENGTH * EDGE_LENGTH;
   localparam int AW         = $clog2(STORE_SIZE);
   localparam int CW         = $clog2(STORE_SIZE + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_READ = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   cfg_type                 cfg_ff, cfg_in;
   logic                    cfg_hit;
   logic                    restart_pend_ff;
   logic [LEN_W-1:0]        rem_ff, rem_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [CW-1:0]           count_ff, count_in, count_inc;
   logic                    rd_ok_ff, rd_ok_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [VAL_W-1:0]        res_value_ff, res_value_in;
   logic [FILL_W-1:0]       res_fill_ff, res_fill_in;
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [VAL_W-1:0]        rsp_value_ff;
   logic [FILL_W-1:0]       rsp_fill_ff;

   logic [VALUE_BITS-1:0]   store_mem [STORE_SIZE];
   logic [VALUE_BITS-1:0]   rd_data_ff;
   logic [AW-1:0]           mem_raddr, mem_waddr;
   logic                    mem_we;

   walk_ctl_type            walk_ctl;
   logic signed [IDX_W-1:0] walk_index;
   logic                    idx_ok, full, out_free, req_accept, csr_write;
   logic [IDX_W-1:0]        ridx_ext;

   vrd_walk #(
      .EDGE_LENGTH (EDGE_LENGTH)
   ) u_walk (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .ctl   (walk_ctl),
      .index (walk_index)
   );

   // register file
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in  = cfg_ff;
      cfg_hit = 1'b1;
      unique case (csr_bus.index)
         REG_MIDDLE_START:  cfg_in.middle_start  = $signed(csr_bus.data[POS_W-1:0]);
         REG_MIDDLE_STRIDE: cfg_in.middle_stride = csr_bus.data[STRIDE_W-1:0];
         REG_MIDDLE_END:    cfg_in.middle_end    = $signed(csr_bus.data[POS_W-1:0]);
         REG_MIDDLE_STEP:   cfg_in.middle_step   = $signed(csr_bus.data[STEP_W-1:0]);
         REG_INNER_START:   cfg_in.inner_start   = $signed(csr_bus.data[POS_W-1:0]);
         REG_INNER_STRIDE:  cfg_in.inner_stride  = csr_bus.data[STRIDE_W-1:0];
         REG_INNER_END:     cfg_in.inner_end     = $signed(csr_bus.data[POS_W-1:0]);
         REG_INNER_STEP:    cfg_in.inner_step    = $signed(csr_bus.data[STEP_W-1:0]);
         default:           cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff          <= CFG_RST;
         restart_pend_ff <= 1'b0;
      end else begin
         restart_pend_ff <= csr_write && cfg_hit;
         if (csr_write && cfg_hit) begin
            cfg_ff <= cfg_in;
         end
      end
   end

   // sequencer
   assign req_bus.ready = (state_ff == ST_IDLE) && !restart_pend_ff;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign idx_ok        = !walk_index[IDX_W-1] && (walk_index < $signed(IDX_W'(STORE_SIZE)));
   assign count_inc     = count_ff + CW'(1);
   assign full          = (count_inc == CW'(STORE_SIZE));
   assign ridx_ext      = IDX_W'(req_bus.read_index);
   assign mem_raddr     = AW'(ridx_ext);
   assign mem_waddr     = AW'(walk_index);

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      rd_ok_in      = rd_ok_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_fill_in   = res_fill_ff;
      walk_ctl      = '0;
      mem_we        = 1'b0;
      if (restart_pend_ff) begin
         walk_ctl.restart = 1'b1;
         count_in         = '0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_bus.mode) begin
                  rd_ok_in = ridx_ext < IDX_W'(STORE_SIZE);
                  state_in = ST_READ;
               end else begin
                  rem_in   = req_bus.run_length;
                  val_in   = req_bus.run_value[VALUE_BITS-1:0];
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            res_value_in = '0;
            if (rem_ff == '0) begin
               res_status_in = STAT_RUN_TAKEN;
               res_fill_in   = FILL_W'(count_ff);
               state_in      = ST_DONE;
            end else if (!idx_ok) begin
               res_status_in    = STAT_CORRUPT;
               res_fill_in      = FILL_W'(count_ff);
               walk_ctl.restart = 1'b1;
               count_in         = '0;
               state_in         = ST_DONE;
            end else begin
               mem_we           = 1'b1;
               walk_ctl.advance = 1'b1;
               if (full) begin
                  res_status_in    = STAT_CHUNK_DONE;
                  res_fill_in      = FILL_W'(count_inc);
                  walk_ctl.restart = 1'b1;
                  count_in         = '0;
                  state_in         = ST_DONE;
               end else begin
                  count_in = count_inc;
                  rem_in   = rem_ff - LEN_W'(1);
               end
            end
         end
         ST_READ: begin
            res_status_in = STAT_READ_DATA;
            res_value_in  = rd_ok_ff ? VAL_W'(rd_data_ff) : '0;
            res_fill_in   = FILL_W'(count_ff);
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      val_ff        <= val_in;
      rd_ok_ff      <= rd_ok_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_fill_ff   <= res_fill_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_fill_ff   <= res_fill_ff;
      end
   end

   // voxel store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= val_ff;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.read_value   = rsp_value_ff;
   assign rsp_bus.filled_count = rsp_fill_ff;

endmodule

/* tb/voxel_rle_decoder_core_checker.sv */
// checker of the voxel run-length decoder: watches the channels, predicts and compares
module voxel_rle_decoder_core_checker #(
   parameter int EDGE_LENGTH = 32,
   parameter int VALUE_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   vrd_req_if   req_bus,
   vrd_rsp_if   rsp_bus,
   vrd_csr_if   csr_bus,
   output int   fail_count,
   output int   open_count,
   output int   run_count,
   output int   read_count,
   output int   chunk_count,
   output int   corrupt_count
);
   import vrd_pkg::*;

   localparam int LAYER_SIZE = EDGE_LENGTH * EDGE_LENGTH;
   localparam int STORE_SIZE = LAYER_SIZE * EDGE_LENGTH;
   localparam int PEND_DEPTH = 64;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    read_value;
      logic [FILL_W-1:0]   filled_count;
   } voxel_result_type;

   cfg_type                 walk_cfg = CFG_RST;
   logic [LAYER_W-1:0]      layer_at = '0;
   logic signed [POS_W-1:0] middle_at = '0;
   logic signed [POS_W-1:0] inner_at = '0;
   int unsigned             placed = 0;
   logic [VAL_W-1:0]        voxels [STORE_SIZE];
   voxel_result_type        awaited [PEND_DEPTH];
   int                      head = 0;
   int                      tail = 0;
   int                      pending = 0;
   int                      fails = 0;
   int                      runs = 0;
   int                      reads = 0;
   int                      chunks = 0;
   int                      corrupts = 0;

   function automatic void restart_walk();
      layer_at  = '0;
      middle_at = walk_cfg.middle_start;
      inner_at  = walk_cfg.inner_start;
      placed    = 0;
   endfunction

   function automatic void step_walk();
      inner_at = inner_at + $signed(walk_cfg.inner_step);
      if (inner_at == walk_cfg.inner_end) begin
         inner_at  = walk_cfg.inner_start;
         middle_at = middle_at + $signed(walk_cfg.middle_step);
         if (middle_at == walk_cfg.middle_end) begin
            middle_at = walk_cfg.middle_start;
            layer_at  = layer_at + 1'b1;
         end
      end
   endfunction

   function automatic void write_register(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      logic known;
      known = 1'b1;
      case (index)
         REG_MIDDLE_START:  walk_cfg.middle_start  = data[POS_W-1:0];
         REG_MIDDLE_STRIDE: walk_cfg.middle_stride = data[STRIDE_W-1:0];
         REG_MIDDLE_END:    walk_cfg.middle_end    = data[POS_W-1:0];
         REG_MIDDLE_STEP:   walk_cfg.middle_step   = data[STEP_W-1:0];
         REG_INNER_START:   walk_cfg.inner_start   = data[POS_W-1:0];
         REG_INNER_STRIDE:  walk_cfg.inner_stride  = data[STRIDE_W-1:0];
         REG_INNER_END:     walk_cfg.inner_end     = data[POS_W-1:0];
         REG_INNER_STEP:    walk_cfg.inner_step    = data[STEP_W-1:0];
         default:           known = 1'b0;
      endcase
      if (known) restart_walk();
   endfunction

   function automatic voxel_result_type decode_item(input logic mode,
                                                    input logic [LEN_W-1:0] run_length,
                                                    input logic [VAL_W-1:0] run_value,
                                                    input logic [RIDX_W-1:0] read_index);
      voxel_result_type res;
      logic [VAL_W-1:0] stored_value;
      logic             stop;
      int               idx;
      int               q;
      res = '0;
      res.status = STAT_RUN_TAKEN;
      stop = 1'b0;
      if (mode) begin
         res.status = STAT_READ_DATA;
         if (int'(read_index) < STORE_SIZE) res.read_value = voxels[read_index];
      end else begin
         stored_value = run_value & VAL_W'((32'd1 << VALUE_BITS) - 1);
         for (q = 0; q < int'(run_length) && !stop; q++) begin
            idx = int'(layer_at) * LAYER_SIZE
                + int'(middle_at) * int'(walk_cfg.middle_stride)
                + int'(inner_at) * int'(walk_cfg.inner_stride);
            if (idx < 0 || idx >= STORE_SIZE) begin
               res.status = STAT_CORRUPT;
               stop = 1'b1;
            end else begin
               voxels[idx] = stored_value;
               placed++;
               step_walk();
               if (placed >= STORE_SIZE) begin
                  res.status = STAT_CHUNK_DONE;
                  stop = 1'b1;
               end
            end
         end
      end
      res.filled_count = placed[FILL_W-1:0];
      if (!mode && res.status != STAT_RUN_TAKEN) restart_walk();
      return res;
   endfunction

   always @(posedge clock) begin : watch
      voxel_result_type seen;
      voxel_result_type want;
      if (reset) begin
         walk_cfg = CFG_RST;
         restart_walk();
         head    = 0;
         tail    = 0;
         pending = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) write_register(csr_bus.index, csr_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status       = rsp_bus.status;
            seen.read_value   = rsp_bus.read_value;
            seen.filled_count = rsp_bus.filled_count;
            if (pending == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: result with none expected: status %0d value %h filled %0d",
                           $time, seen.status, seen.read_value, seen.filled_count);
            end else begin
               want    = awaited[head];
               head    = (head + 1) % PEND_DEPTH;
               pending = pending - 1;
               if (seen.status !== want.status || seen.read_value !== want.read_value
                   || seen.filled_count !== want.filled_count) begin
                  fails++;
                  if (fails <= 10)
                     $display({"%0t: mismatch: expected status %0d value %h filled %0d,",
                               " got status %0d value %h filled %0d"},
                              $time, want.status, want.read_value, want.filled_count,
                              seen.status, seen.read_value, seen.filled_count);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = decode_item(req_bus.mode, req_bus.run_length, req_bus.run_value,
                               req_bus.read_index);
            if (pending == PEND_DEPTH) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: too many items without a result", $time);
            end else begin
               awaited[tail] = want;
               tail          = (tail + 1) % PEND_DEPTH;
               pending       = pending + 1;
            end
            if (req_bus.mode) reads++;
            else runs++;
            if (want.status == STAT_CHUNK_DONE) chunks++;
            if (want.status == STAT_CORRUPT) corrupts++;
         end
      end
      fail_count    <= fails;
      open_count    <= pending;
      run_count     <= runs;
      read_count    <= reads;
      chunk_count   <= chunks;
      corrupt_count <= corrupts;
   end

endmodule

/* tb/voxel_rle_decoder_core_tb.sv */
// testbench top of the voxel run-length decoder: clock, reset, stimulus and verdict
module voxel_rle_decoder_core_tb;
   import vrd_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 75;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;
   logic quiet = 1'b0;
   int   cycles = 0;
   int   stall_left = 0;
   int   settings = 0;
   int   fail_count;
   int   open_count;
   int   run_count;
   int   read_count;
   int   chunk_count;
   int   corrupt_count;

   vrd_req_if req_bus ();
   vrd_rsp_if rsp_bus ();
   vrd_csr_if csr_bus ();

   voxel_rle_decoder_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   voxel_rle_decoder_core_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .run_count     (run_count),
      .read_count    (read_count),
      .chunk_count   (chunk_count),
      .corrupt_count (corrupt_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("FAIL voxel_rle_decoder_core");
         $finish;
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
         stall_left    <= $urandom_range(0, 8);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_item(input logic mode, input logic [LEN_W-1:0] run_length,
                            input logic [VAL_W-1:0] run_value,
                            input logic [RIDX_W-1:0] read_index);
      int gap;
      gap = 0;
      if (!calm && !quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.run_length <= run_length;
      req_bus.run_value  <= run_value;
      req_bus.read_index <= read_index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // pad, or its inverse for the inner step, fills the register bits above each field
   task automatic apply_settings(input cfg_type c, input logic [8:0] pad, input logic odd_write);
      write_reg(REG_MIDDLE_START,  {pad[3:0], c.middle_start});
      write_reg(REG_MIDDLE_STRIDE, c.middle_stride);
      write_reg(REG_MIDDLE_END,    {pad[7:4], c.middle_end});
      write_reg(REG_MIDDLE_STEP,   {pad, c.middle_step});
      write_reg(REG_INNER_START,   {pad[8:5], c.inner_start});
      write_reg(REG_INNER_STRIDE,  c.inner_stride);
      write_reg(REG_INNER_END,     {pad[4:1], c.inner_end});
      write_reg(REG_INNER_STEP,    {~pad, c.inner_step});
      if (odd_write)
         write_reg(CSR_IDX_W'($urandom_range(8, 15)), CSR_DATA_W'($urandom));
      csr_bus.valid <= 1'b0;
      settings++;
   endtask

   // {start, end, step} of one axis that stays inside the cube
   function automatic logic [2*POS_W+STEP_W-1:0] pick_axis();
      int  a;
      logic full;
      a    = $urandom_range(0, 31);
      full = $urandom_range(0, 1);
      if ($urandom_range(0, 1))
         return {POS_W'(full ? 0 : a), POS_W'(full ? 32 : $urandom_range(a + 1, 32)), 2'sd1};
      return {POS_W'(full ? 31 : a), POS_W'(full ? -1 : int'($urandom_range(0, a)) - 1), -2'sd1};
   endfunction

   function automatic cfg_type pick_settings();
      cfg_type     c;
      logic [63:0] raw;
      if ($urandom_range(0, 9) < 6) begin
         if ($urandom_range(0, 1)) begin
            c.inner_stride  = 11'd1;
            c.middle_stride = 11'd32;
         end else begin
            c.inner_stride  = 11'd32;
            c.middle_stride = 11'd1;
         end
         {c.inner_start, c.inner_end, c.inner_step}    = pick_axis();
         {c.middle_start, c.middle_end, c.middle_step} = pick_axis();
      end else begin
         raw = {$urandom, $urandom};
         c   = raw[$bits(cfg_type)-1:0];
      end
      return c;
   endfunction

   initial begin
      cfg_type c;
      int      phase;
      int      n;
      req_bus.valid      = 1'b0;
      req_bus.mode       = 1'b0;
      req_bus.run_length = '0;
      req_bus.run_value  = '0;
      req_bus.read_index = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset traversal: empty run, one run that fills the whole store, reads and short runs
      send_item(1'b0, 16'd0, 16'h1234, 15'h7FFF);
      send_item(1'b0, 16'hFFFF, 16'hFFFF, 15'h0000);
      send_item(1'b1, 16'hFFFF, 16'hFFFF, 15'h0000);
      send_item(1'b1, 16'h0000, 16'h0000, 15'h7FFF);
      send_item(1'b0, 16'd1, 16'h0000, 15'h7FFF);
      send_item(1'b0, 16'd33, 16'hA5C3, 15'h0000);
      send_item(1'b1, 16'h5555, 16'hAAAA, 15'd0);
      send_item(1'b1, 16'hAAAA, 16'h5555, 15'd33);
      send_item(1'b1, 16'h0000, 16'h0000, 15'd34);
      wait_idle();

      // all registers zero: every voxel bumps the layer until it leaves the cube
      c = '0;
      apply_settings(c, 9'h000, 1'b0);
      send_item(1'b0, 16'd40, 16'h0F0F, 15'd0);
      send_item(1'b1, 16'd0, 16'd0, 15'd1024);
      wait_idle();

      // all registers ones: negative index on the first voxel
      c = '1;
      apply_settings(c, 9'h1FF, 1'b1);
      send_item(1'b0, 16'd5, 16'h3C3C, 15'd0);
      wait_idle();

      // index beyond the store
      c = CFG_RST;
      c.middle_start  = 7'sd31;
      c.middle_stride = 11'd2047;
      apply_settings(c, 9'h000, 1'b0);
      send_item(1'b0, 16'd3, 16'h1111, 15'd0);
      wait_idle();

      // inner position wraps through the 7 bit limit, middle steps by minus two
      c = CFG_RST;
      c.inner_stride = 11'd0;
      c.inner_start  = 7'sd62;
      c.inner_end    = -7'sd63;
      c.middle_step  = -2'sd2;
      apply_settings(c, 9'h0A5, 1'b0);
      send_item(1'b0, 16'd70, 16'h7777, 15'd0);
      send_item(1'b1, 16'd0, 16'd0, 15'd0);
      wait_idle();

      for (phase = 0; phase < PHASES; phase++) begin
         calm  <= ($urandom_range(0, 3) == 0);
         quiet <= (phase == PHASES - 1);
         apply_settings(pick_settings(), 9'($urandom), $urandom_range(0, 1));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 40 && phase % 2 == 0)
               send_item(1'b0, LEN_W'($urandom_range(32768, 65535)), VAL_W'($urandom),
                         RIDX_W'($urandom));
            else if ($urandom_range(0, 3) == 0)
               send_item(1'b1, LEN_W'($urandom), VAL_W'($urandom), RIDX_W'($urandom));
            else if ($urandom_range(0, 49) == 0)
               send_item(1'b0, LEN_W'($urandom_range(65, 1200)), VAL_W'($urandom),
                         RIDX_W'($urandom));
            else
               send_item(1'b0, LEN_W'($urandom_range(0, 64)), VAL_W'($urandom),
                         RIDX_W'($urandom));
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d runs and %0d reads under %0d register settings",
               run_count, read_count, settings);
      $display("%0d full chunks and %0d corrupt indexes among the results",
               chunk_count, corrupt_count);
      if (fail_count == 0 && open_count == 0) begin
         $display("PASS voxel_rle_decoder_core");
      end else begin
         $display("FAIL voxel_rle_decoder_core");
      end
      $finish;
   end

endmodule
